// ----- rtl/gcab_pkg.sv -----
// ----------------------------------------------------------------------------
// gcab_pkg
// shared constants, types and the linear-light table builder for the
// gamma-corrected argb blend
// ----------------------------------------------------------------------------
package gcab_pkg;

  // blend fraction, unsigned q1.16
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned FRAC_W    = FRAC_BITS + 1;
  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

  // colour codes
  localparam int unsigned CODE_W = 8;
  localparam int unsigned CODES  = 1 << CODE_W;
  localparam int unsigned NUM_CH = 3;

  // linear light, code^2.2 with LIN_FRAC_BITS fraction bits; 255^2.2 needs 18 bits
  localparam int unsigned LIN_FRAC_BITS = 8;
  localparam int unsigned LIN_W         = 18 + LIN_FRAC_BITS;

  // products of the interpolation
  localparam int unsigned PROD_W       = LIN_W + FRAC_W;
  localparam int unsigned ALPHA_PROD_W = CODE_W + FRAC_W;

  // exact root search used to build the table
  localparam int unsigned ROOT_BITS = 35;
  localparam int unsigned BIG_W     = 200;
  localparam int unsigned EXP_NUM   = 11;
  localparam int unsigned EXP_DEN   = 5;

  // word carried through the inverse search stages
  typedef struct packed {
    logic [NUM_CH-1:0][LIN_W-1:0]  lin;
    logic [NUM_CH-1:0][CODE_W-1:0] code;
    logic [CODE_W-1:0]             alpha;
  } srch_t;

  // largest v with v^5 <= code^11 * 2^(5*LIN_FRAC_BITS), evaluated at elaboration
  function automatic logic [LIN_W-1:0] lin_entry(input int unsigned code);
    logic [BIG_W-1:0]     tgt;
    logic [BIG_W-1:0]     trial;
    logic [BIG_W-1:0]     base;
    logic [BIG_W-1:0]     cbig;
    logic [ROOT_BITS-1:0] v;
    logic [ROOT_BITS-1:0] cand;
    cbig = BIG_W'(code);
    tgt  = BIG_W'(1);
    for (int i = 0; i < EXP_NUM; i++) begin
      tgt = tgt * cbig;
    end
    tgt = tgt << (EXP_DEN * LIN_FRAC_BITS);
    v = '0;
    for (int b = ROOT_BITS - 1; b >= 0; b--) begin
      cand  = v | (ROOT_BITS'(1) << b);
      base  = BIG_W'(cand);
      trial = base;
      for (int j = 1; j < EXP_DEN; j++) begin
        trial = trial * base;
      end
      if (trial <= tgt) begin
        v = cand;
      end
    end
    return v[LIN_W-1:0];
  endfunction

endpackage

// ----- rtl/gcab_in_if.sv -----
// ----------------------------------------------------------------------------
// gcab_in_if
// input channel: two argb colours and a blend fraction
// ----------------------------------------------------------------------------
interface gcab_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_color;
  logic [31:0] finish_color;
  logic [16:0] blend_fraction;

  modport source (output valid, start_color, finish_color, blend_fraction, input ready);
  modport sink   (input valid, start_color, finish_color, blend_fraction, output ready);
endinterface

// ----- rtl/gcab_out_if.sv -----
// ----------------------------------------------------------------------------
// gcab_out_if
// output channel: one blended argb colour
// ----------------------------------------------------------------------------
interface gcab_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] blended_color;

  modport source (output valid, blended_color, input ready);
  modport sink   (input valid, blended_color, output ready);
endinterface

// ----- rtl/gcab_lin_rom.sv -----
// ----------------------------------------------------------------------------
// gcab_lin_rom
// constant code to linear-light table, combinational read
// ----------------------------------------------------------------------------
module gcab_lin_rom (
  input  logic [gcab_pkg::CODE_W-1:0] code_i,
  output logic [gcab_pkg::LIN_W-1:0]  lin_o
);
  import gcab_pkg::*;

  logic [LIN_W-1:0] tab [CODES];

  for (genvar k = 0; k < CODES; k++) begin : g_entry
    localparam logic [LIN_W-1:0] Entry = lin_entry(k);
    assign tab[k] = Entry;
  end

  assign lin_o = tab[code_i];

endmodule

// ----- rtl/gcab_search_stage.sv -----
// ----------------------------------------------------------------------------
// gcab_search_stage
// one pipeline stage of the inverse table search: resolves STEP_BITS code
// bits per channel, from TOP_BIT down, and registers the word
// ----------------------------------------------------------------------------
module gcab_search_stage #(
  parameter int unsigned TOP_BIT   = 7,
  parameter int unsigned STEP_BITS = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  gcab_pkg::srch_t data_i,
  output logic            valid_o,
  output gcab_pkg::srch_t data_o
);
  import gcab_pkg::*;

  logic  valid_q;
  srch_t data_d;
  srch_t data_q;

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    // code after each resolved bit
    logic [CODE_W-1:0] k [STEP_BITS+1];
    assign k[0] = data_i.code[ch];

    for (genvar s = 0; s < STEP_BITS; s++) begin : g_bit
      localparam int unsigned Bit = TOP_BIT - s;
      logic [CODE_W-1:0] cand;
      logic [LIN_W-1:0]  cand_lin;

      assign cand = k[s] | (CODE_W'(1) << Bit);

      gcab_lin_rom u_rom (
        .code_i (cand),
        .lin_o  (cand_lin)
      );

      assign k[s+1] = (cand_lin <= data_i.lin[ch]) ? cand : k[s];
    end

    assign data_d.code[ch] = k[STEP_BITS];
  end

  assign data_d.lin   = data_i.lin;
  assign data_d.alpha = data_i.alpha;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/gamma_correct_argb_blend.sv -----
// throughput: one word per cycle, no bubbles; a stalled output holds the whole pipe
// stages: table lookup, multiply, add and scale, then four search stages of 2 code bits
// reset: asynchronous active low, clears every stage valid bit; data registers are not reset
// ----------------------------------------------------------------------------
// gamma_correct_argb_blend
// gamma 2.2 correct blend of two argb8888 colours; red, green and blue are
// interpolated in linear light and mapped back by exact table search, alpha
// is interpolated on the raw codes
// ----------------------------------------------------------------------------
module gamma_correct_argb_blend (
  input  logic       clk_i,
  input  logic       rst_ni,
  gcab_in_if.sink    src_i,
  gcab_out_if.source res_o
);
  import gcab_pkg::*;

  localparam int unsigned SEARCH_STEPS = 4;
  localparam int unsigned STEP_BITS    = CODE_W / SEARCH_STEPS;

  // global advance: the pipe moves when the output register is free or being taken
  logic en;
  logic out_valid;

  assign en          = !out_valid || res_o.ready;
  assign src_i.ready = en;

  // ---------------------------------------------------------------- stage 1
  // saturate the fraction and expand colour codes to linear light
  logic [FRAC_W-1:0] frac_sat;
  assign frac_sat = (src_i.blend_fraction > FRAC_ONE) ? FRAC_ONE : src_i.blend_fraction;

  logic                           v1_q;
  logic [FRAC_W-1:0]              f1_q;
  logic [CODE_W-1:0]              as1_q;
  logic [CODE_W-1:0]              ae1_q;
  logic [NUM_CH-1:0][LIN_W-1:0]   ls1_d;
  logic [NUM_CH-1:0][LIN_W-1:0]   le1_d;
  logic [NUM_CH-1:0][LIN_W-1:0]   ls1_q;
  logic [NUM_CH-1:0][LIN_W-1:0]   le1_q;

  // channel 0 is blue (bits 7..0), 1 green, 2 red
  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_expand
    gcab_lin_rom u_rom_s (
      .code_i (src_i.start_color[CODE_W*ch +: CODE_W]),
      .lin_o  (ls1_d[ch])
    );
    gcab_lin_rom u_rom_e (
      .code_i (src_i.finish_color[CODE_W*ch +: CODE_W]),
      .lin_o  (le1_d[ch])
    );
  end

  // ---------------------------------------------------------------- stage 2
  // weight both endpoints
  logic [FRAC_W-1:0]               omf1;
  logic                            v2_q;
  logic [NUM_CH-1:0][PROD_W-1:0]   ps2_d;
  logic [NUM_CH-1:0][PROD_W-1:0]   pe2_d;
  logic [NUM_CH-1:0][PROD_W-1:0]   ps2_q;
  logic [NUM_CH-1:0][PROD_W-1:0]   pe2_q;
  logic [ALPHA_PROD_W-1:0]         pas2_d;
  logic [ALPHA_PROD_W-1:0]         pae2_d;
  logic [ALPHA_PROD_W-1:0]         pas2_q;
  logic [ALPHA_PROD_W-1:0]         pae2_q;

  assign omf1 = FRAC_ONE - f1_q;

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_mul
    assign ps2_d[ch] = PROD_W'(ls1_q[ch]) * PROD_W'(omf1);
    assign pe2_d[ch] = PROD_W'(le1_q[ch]) * PROD_W'(f1_q);
  end
  assign pas2_d = ALPHA_PROD_W'(as1_q) * ALPHA_PROD_W'(omf1);
  assign pae2_d = ALPHA_PROD_W'(ae1_q) * ALPHA_PROD_W'(f1_q);

  // ---------------------------------------------------------------- stage 3
  // add, drop the fraction bits (floor); search starts from code zero
  logic                            v3_q;
  srch_t                           s3_d;
  srch_t                           s3_q;
  logic [NUM_CH-1:0][PROD_W:0]     sum3;
  logic [ALPHA_PROD_W:0]           asum3;

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_sum
    assign sum3[ch]        = {1'b0, ps2_q[ch]} + {1'b0, pe2_q[ch]};
    assign s3_d.lin[ch]    = sum3[ch][FRAC_BITS +: LIN_W];
    assign s3_d.code[ch]   = '0;
  end
  assign asum3      = {1'b0, pas2_q} + {1'b0, pae2_q};
  assign s3_d.alpha = asum3[FRAC_BITS +: CODE_W];

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= src_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q   <= frac_sat;
      as1_q  <= src_i.start_color[31:24];
      ae1_q  <= src_i.finish_color[31:24];
      ls1_q  <= ls1_d;
      le1_q  <= le1_d;
      ps2_q  <= ps2_d;
      pe2_q  <= pe2_d;
      pas2_q <= pas2_d;
      pae2_q <= pae2_d;
      s3_q   <= s3_d;
    end
  end

  // ---------------------------------------------------------------- stages 4 to 7
  // binary search for the largest code whose linear value does not exceed the blend
  logic  sv [SEARCH_STEPS+1];
  srch_t sd [SEARCH_STEPS+1];

  assign sv[0] = v3_q;
  assign sd[0] = s3_q;

  for (genvar st = 0; st < SEARCH_STEPS; st++) begin : g_search
    gcab_search_stage #(
      .TOP_BIT   (CODE_W - 1 - st * STEP_BITS),
      .STEP_BITS (STEP_BITS)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sv[st]),
      .data_i  (sd[st]),
      .valid_o (sv[st+1]),
      .data_o  (sd[st+1])
    );
  end

  // last search stage is the output register
  assign out_valid           = sv[SEARCH_STEPS];
  assign res_o.valid         = out_valid;
  assign res_o.blended_color = {sd[SEARCH_STEPS].alpha,
                                sd[SEARCH_STEPS].code[2],
                                sd[SEARCH_STEPS].code[1],
                                sd[SEARCH_STEPS].code[0]};

endmodule
